// ===== rtl/scsidcd_pkg.sv =====
package scsidcd_pkg;

    // block size of the medium in bytes
    localparam int unsigned BLOCK_SIZE = 512;

    // derived reply values
    localparam logic [9:0]  WRITE_DATA_LEN    = 10'(BLOCK_SIZE % 1024);
    localparam logic [31:0] BLOCK_BYTES       = 32'(BLOCK_SIZE);
    localparam logic [9:0]  CAPACITY_DATA_LEN = 10'd8;
    localparam logic [16:0] SHORT_COUNT_ZERO  = 17'd256;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_BLOCKS    = 2'd0;
    localparam logic [1:0] CFG_CARD_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_WRITE_PROTECT = 2'd2;
    localparam logic [1:0] CFG_CARD_PRESENT  = 2'd3;

    // operation codes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REZERO          = 8'h01;
    localparam logic [7:0] OP_FORMAT_UNIT     = 8'h04;
    localparam logic [7:0] OP_READ6           = 8'h08;
    localparam logic [7:0] OP_WRITE6          = 8'h0A;
    localparam logic [7:0] OP_SEEK6           = 8'h0B;
    localparam logic [7:0] OP_START_STOP      = 8'h1B;
    localparam logic [7:0] OP_MEDIUM_REMOVAL  = 8'h1E;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;
    localparam logic [7:0] OP_WRITE10         = 8'h2A;
    localparam logic [7:0] OP_SEEK10          = 8'h2B;
    localparam logic [7:0] OP_PREFETCH        = 8'h34;
    localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;
    localparam logic [7:0] OP_LOCK_CACHE      = 8'h36;

    typedef enum logic [1:0] {
        EV_COMMAND    = 2'd0,
        EV_BLOCK_DONE = 2'd1,
        EV_POWER_ON   = 2'd2,
        EV_BUS_RESET  = 2'd3
    } event_t;

    // bus phase; in a result the command code means unchanged
    typedef enum logic [1:0] {
        PH_COMMAND  = 2'd0,
        PH_STATUS   = 2'd1,
        PH_DATA_IN  = 2'd2,
        PH_DATA_OUT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SK_NONE            = 2'd0,
        SK_NOT_READY       = 2'd1,
        SK_ILLEGAL_REQUEST = 2'd2
    } sense_key_t;

    typedef enum logic [2:0] {
        ASC_NONE              = 3'd0,
        ASC_INVALID_CDB_FIELD = 3'd1,
        ASC_NO_MEDIUM         = 3'd2,
        ASC_WRITE_PROTECTED   = 3'd3,
        ASC_LBA_OUT_OF_RANGE  = 3'd4,
        ASC_START_REQUIRED    = 3'd5,
        ASC_NOT_READY_OTHER   = 3'd6
    } asc_t;

    typedef enum logic [2:0] {
        ACT_NONE           = 3'd0,
        ACT_PREPARE_READ   = 3'd1,
        ACT_PREPARE_WRITE  = 3'd2,
        ACT_COMPLETE_READ  = 3'd3,
        ACT_COMPLETE_WRITE = 3'd4
    } action_t;

    typedef struct packed {
        logic [31:0] max_blocks;
        logic [31:0] card_capacity;
        logic        write_protect;
        logic        card_present;
    } cfg_t;

    typedef struct packed {
        event_t     cmd;
        logic [7:0] opcode;
        logic [7:0] cdb_byte1;
        logic [7:0] cdb_byte2;
        logic [7:0] cdb_byte3;
        logic [7:0] cdb_byte4;
        logic [7:0] cdb_byte5;
        logic [7:0] cdb_byte7;
        logic [7:0] cdb_byte8;
        logic       init_ok;
    } item_t;

    typedef struct packed {
        logic        unit_started;
        logic        medium_present;
        logic        unit_initialised;
        logic [31:0] capacity_blocks;
        logic [15:0] transfer_length;
        logic [15:0] blocks_done;
        phase_t      bus_phase;
    } unit_state_t;

    // unit state after reset: started, nothing else known
    localparam unit_state_t UNIT_STATE_RESET = '{
        unit_started:     1'b1,
        medium_present:   1'b0,
        unit_initialised: 1'b0,
        capacity_blocks:  32'd0,
        transfer_length:  16'd0,
        blocks_done:      16'd0,
        bus_phase:        PH_COMMAND
    };

    typedef struct packed {
        logic        handled;
        logic        check_status;
        sense_key_t  sense_key;
        asc_t        sense_asc;
        phase_t      new_phase;
        logic [9:0]  data_length;
        logic [31:0] last_block;
        logic [31:0] block_bytes;
        logic [31:0] start_block;
        logic [15:0] block_count;
        action_t     card_action;
    } result_t;

endpackage

// ===== rtl/scsidcd_core.sv =====
module scsidcd_core (
    input  scsidcd_pkg::item_t       item,
    input  scsidcd_pkg::cfg_t        cfg,
    input  scsidcd_pkg::unit_state_t state,
    output scsidcd_pkg::unit_state_t state_next,
    output scsidcd_pkg::result_t     result
);
    import scsidcd_pkg::*;

    logic [31:0] lba6;
    logic [31:0] lba10;
    logic [16:0] cnt6;
    logic [16:0] cnt10;
    logic        is_short;
    logic        is_write;
    logic [31:0] xfer_lba;
    logic [16:0] xfer_cnt;
    logic [32:0] xfer_end;
    logic        xfer_over;
    logic [31:0] seek_lba;
    logic        seek_over;
    logic [31:0] clamped_capacity;
    logic        ready;
    asc_t        not_ready_asc;
    logic [15:0] done_inc;

    function automatic result_t fail(result_t r, sense_key_t key, asc_t asc);
        result_t f;
        f              = r;
        f.check_status = 1'b1;
        f.sense_key    = key;
        f.sense_asc    = asc;
        f.new_phase    = PH_STATUS;
        return f;
    endfunction

    // descriptor field extraction
    assign lba6  = {11'd0, item.cdb_byte1[4:0], item.cdb_byte2, item.cdb_byte3};
    assign lba10 = {item.cdb_byte2, item.cdb_byte3, item.cdb_byte4, item.cdb_byte5};
    assign cnt6  = (item.cdb_byte4 == 8'd0) ? SHORT_COUNT_ZERO : {9'd0, item.cdb_byte4};
    assign cnt10 = {1'b0, item.cdb_byte7, item.cdb_byte8};

    // transfer operands and the 33-bit range check
    assign is_short  = (item.opcode == OP_READ6) || (item.opcode == OP_WRITE6);
    assign is_write  = (item.opcode == OP_WRITE6) || (item.opcode == OP_WRITE10);
    assign xfer_lba  = is_short ? lba6 : lba10;
    assign xfer_cnt  = is_short ? cnt6 : cnt10;
    assign xfer_end  = {1'b0, xfer_lba} + {16'd0, xfer_cnt};
    assign xfer_over = xfer_end > {1'b0, state.capacity_blocks};

    // seek range check
    assign seek_lba  = (item.opcode == OP_SEEK6) ? lba6 : lba10;
    assign seek_over = seek_lba >= state.capacity_blocks;

    // capacity after a successful card init
    assign clamped_capacity = ((cfg.max_blocks != 32'd0) && (cfg.card_capacity > cfg.max_blocks))
                              ? cfg.max_blocks : cfg.card_capacity;

    // readiness
    assign ready = state.unit_started && state.medium_present && state.unit_initialised;
    always_comb
    begin
        priority if (!state.unit_started)
            not_ready_asc = ASC_START_REQUIRED;
        else if (!state.medium_present)
            not_ready_asc = ASC_NO_MEDIUM;
        else
            not_ready_asc = ASC_NOT_READY_OTHER;
    end

    assign done_inc = state.blocks_done + 16'd1;

    // event decode and state update
    always_comb
    begin
        state_next = state;
        result     = '0;
        unique case (item.cmd)
            EV_COMMAND:
            begin
                state_next.bus_phase = PH_COMMAND;
                result.handled       = 1'b1;
                if (item.opcode == OP_START_STOP)
                begin
                    if (item.cdb_byte4[0])
                    begin
                        state_next.unit_started = 1'b1;
                        if (!state.unit_initialised && item.init_ok)
                        begin
                            state_next.unit_initialised = 1'b1;
                            state_next.capacity_blocks  = clamped_capacity;
                        end
                    end
                    else
                    begin
                        state_next.unit_started = 1'b0;
                    end
                end
                else if (!ready)
                begin
                    result = fail(result, SK_NOT_READY, not_ready_asc);
                end
                else
                begin
                    unique case (item.opcode)
                        OP_READ6, OP_READ10, OP_WRITE6, OP_WRITE10:
                        begin
                            if (is_write && cfg.write_protect)
                                result = fail(result, SK_ILLEGAL_REQUEST, ASC_WRITE_PROTECTED);
                            else if (xfer_over)
                                result = fail(result, SK_ILLEGAL_REQUEST, ASC_LBA_OUT_OF_RANGE);
                            else
                            begin
                                result.start_block         = xfer_lba;
                                result.block_count         = xfer_cnt[15:0];
                                state_next.transfer_length = xfer_cnt[15:0];
                                state_next.blocks_done     = 16'd0;
                                if (xfer_cnt == 17'd0)
                                    result.new_phase = PH_STATUS;
                                else if (is_write)
                                begin
                                    result.new_phase   = PH_DATA_OUT;
                                    result.data_length = WRITE_DATA_LEN;
                                    result.card_action = ACT_PREPARE_WRITE;
                                end
                                else
                                begin
                                    result.new_phase   = PH_DATA_IN;
                                    result.card_action = ACT_PREPARE_READ;
                                end
                            end
                        end
                        OP_READ_CAPACITY:
                        begin
                            if (!item.cdb_byte8[0] && (lba10 != 32'd0))
                                result = fail(result, SK_ILLEGAL_REQUEST, ASC_INVALID_CDB_FIELD);
                            else if (state.capacity_blocks != 32'd0)
                            begin
                                result.last_block  = state.capacity_blocks - 32'd1;
                                result.block_bytes = BLOCK_BYTES;
                                result.data_length = CAPACITY_DATA_LEN;
                                result.new_phase   = PH_DATA_IN;
                            end
                            else
                                result = fail(result, SK_NOT_READY, ASC_NO_MEDIUM);
                        end
                        OP_SEEK6, OP_SEEK10:
                        begin
                            if (seek_over)
                                result = fail(result, SK_ILLEGAL_REQUEST, ASC_LBA_OUT_OF_RANGE);
                        end
                        // test unit ready and cache or media no-ops: nothing more to do
                        OP_TEST_UNIT_READY, OP_FORMAT_UNIT, OP_LOCK_CACHE, OP_PREFETCH,
                        OP_MEDIUM_REMOVAL, OP_REZERO, OP_SYNC_CACHE:
                        begin
                            result.handled = 1'b1;
                        end
                        default:
                        begin
                            result.handled = 1'b0;
                        end
                    endcase
                end
                if (result.new_phase != PH_COMMAND)
                    state_next.bus_phase = result.new_phase;
            end
            EV_BLOCK_DONE:
            begin
                if (((state.bus_phase == PH_DATA_IN) || (state.bus_phase == PH_DATA_OUT))
                    && (state.blocks_done != state.transfer_length))
                begin
                    state_next.blocks_done = done_inc;
                    if (done_inc >= state.transfer_length)
                    begin
                        result.new_phase           = PH_STATUS;
                        result.card_action         = (state.bus_phase == PH_DATA_OUT)
                                                     ? ACT_COMPLETE_WRITE : ACT_COMPLETE_READ;
                        state_next.bus_phase       = PH_STATUS;
                        state_next.transfer_length = 16'd0;
                        state_next.blocks_done     = 16'd0;
                    end
                end
            end
            EV_POWER_ON:
            begin
                state_next.capacity_blocks  = 32'd0;
                state_next.transfer_length  = 16'd0;
                state_next.blocks_done      = 16'd0;
                state_next.bus_phase        = PH_COMMAND;
                state_next.unit_started     = 1'b1;
                state_next.medium_present   = cfg.card_present;
                state_next.unit_initialised = 1'b0;
                if (cfg.card_present && item.init_ok)
                begin
                    state_next.unit_initialised = 1'b1;
                    state_next.capacity_blocks  = clamped_capacity;
                end
            end
            EV_BUS_RESET:
            begin
                state_next.transfer_length = 16'd0;
                state_next.blocks_done     = 16'd0;
                state_next.bus_phase       = PH_COMMAND;
            end
        endcase
    end

endmodule

// ===== rtl/scsi_disk_command_decoder_unit.sv =====
// Direct-access disk command decoder. Each event on the slave stream (a command
// descriptor, a block-transferred notice, a power-on or a bus reset; kind in
// tuser) produces exactly one result on the master stream: status, sense, the
// next bus phase, READ CAPACITY data and the card action to start. One event
// is taken every clock cycle while the result side does not stall; an event
// is held in the input register and its decode pass is loaded into the result
// register once that register is free, and the input side keeps accepting
// while a result waits as long as the result register is freed in the same
// cycle. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and should only change while no event is in flight.
module scsi_disk_command_decoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // event stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, cdb_byte1, cdb_byte2, cdb_byte3, cdb_byte4, cdb_byte5, cdb_byte7,
    // cdb_byte8, init_ok
    input  logic [71:0]  s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // handled, check_status, sense_key, sense_asc, new_phase, data_length,
    // last_block, block_bytes, start_block, block_count, card_action
    output logic [135:0] m_tdata
);
    import scsidcd_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_next;
    unit_state_t state_reg;
    unit_state_t state_next;
    logic        advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_BLOCKS:    cfg_reg.max_blocks    <= cfg_data;
                CFG_CARD_CAPACITY: cfg_reg.card_capacity <= cfg_data;
                CFG_WRITE_PROTECT: cfg_reg.write_protect <= cfg_data[0];
                CFG_CARD_PRESENT:  cfg_reg.card_present  <= cfg_data[0];
            endcase
        end
    end

    // pipeline flow control
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.cmd       <= event_t'(s_tuser);
            item_reg.opcode    <= s_tdata[7:0];
            item_reg.cdb_byte1 <= s_tdata[15:8];
            item_reg.cdb_byte2 <= s_tdata[23:16];
            item_reg.cdb_byte3 <= s_tdata[31:24];
            item_reg.cdb_byte4 <= s_tdata[39:32];
            item_reg.cdb_byte5 <= s_tdata[47:40];
            item_reg.cdb_byte7 <= s_tdata[55:48];
            item_reg.cdb_byte8 <= s_tdata[63:56];
            item_reg.init_ok   <= s_tdata[64];
        end
    end

    // decode pass
    scsidcd_core u_core (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // unit state, updated as each event leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= UNIT_STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.card_action,
                       result_reg.block_count,
                       result_reg.start_block,
                       result_reg.block_bytes,
                       result_reg.last_block,
                       result_reg.data_length,
                       result_reg.new_phase,
                       result_reg.sense_asc,
                       result_reg.sense_key,
                       result_reg.check_status,
                       result_reg.handled};

`ifndef SYNTH
    // a check condition always moves the bus to status
    a_check_goes_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.check_status |-> result_reg.new_phase == PH_STATUS)
        else $error("check condition without status phase");

    // the block counter never passes the transfer length
    a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.blocks_done <= state_reg.transfer_length)
        else $error("blocks done beyond transfer length");

    // a write setup enters data out with one block of data expected
    a_write_setup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.card_action == ACT_PREPARE_WRITE
        |-> result_reg.new_phase == PH_DATA_OUT && result_reg.data_length == WRITE_DATA_LEN)
        else $error("write setup with wrong phase or length");

    // a bus reset leaves the command phase with no transfer
    a_bus_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.cmd == EV_BUS_RESET
        |=> state_reg.bus_phase == PH_COMMAND && state_reg.transfer_length == 16'd0)
        else $error("bus reset left a transfer behind");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scsidcd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 80;

    // opcodes the unit does not decode
    localparam logic [7:0] OP_UNSUPPORTED     = 8'hC0;
    localparam logic [7:0] OP_UNSUPPORTED_TOP = 8'hFF;

    localparam logic [7:0] MISC_OPS [11] = '{
        OP_TEST_UNIT_READY, OP_READ_CAPACITY, OP_SEEK6, OP_SEEK10, OP_START_STOP,
        OP_REZERO, OP_FORMAT_UNIT, OP_MEDIUM_REMOVAL, OP_PREFETCH, OP_SYNC_CACHE,
        OP_LOCK_CACHE
    };
    localparam logic [7:0] NOOP_OPS [6] = '{
        OP_REZERO, OP_FORMAT_UNIT, OP_MEDIUM_REMOVAL, OP_PREFETCH, OP_SYNC_CACHE,
        OP_LOCK_CACHE
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = CFG_MAX_BLOCKS;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [1:0]   s_tuser = EV_COMMAND;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    scsi_disk_command_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // events waiting to be offered and results the unit still owes
    item_t   pending_events [$];
    result_t awaited_results [$];
    item_t   offered;

    int  mismatches = 0;
    int  results_seen = 0;
    bit  src_idle = 1'b1;
    bit  sink_idle = 1'b1;
    bit  long_hold_req = 1'b0;
    int  src_gap = 0;
    int  sink_stall = 0;
    int  quiet_cycles = 0;

    // configuration copy
    logic [31:0] cfg_max_blocks = '0;
    logic [31:0] cfg_card_capacity = '0;
    bit          cfg_write_protect = 1'b0;
    bit          cfg_card_present = 1'b0;

    // unit state copy
    bit          unit_started = 1'b1;
    bit          medium_present = 1'b0;
    bit          unit_initialised = 1'b0;
    logic [31:0] capacity_blocks = '0;
    logic [15:0] xfer_length = '0;
    logic [15:0] blocks_done = '0;
    phase_t      bus_phase = PH_COMMAND;

    // ---------------------------------------------------------------
    // unit behavior
    // ---------------------------------------------------------------

    function automatic void clear_transfer();
        xfer_length = '0;
        blocks_done = '0;
    endfunction

    // capacity comes from the card, clamped to the configured limit
    function automatic void card_init(input bit ok);
        if (ok)
        begin
            unit_initialised = 1'b1;
            if (cfg_max_blocks != 0 && cfg_card_capacity > cfg_max_blocks)
                capacity_blocks = cfg_max_blocks;
            else
                capacity_blocks = cfg_card_capacity;
        end
    endfunction

    function automatic asc_t ready_fault();
        if (!unit_started)
            return ASC_START_REQUIRED;
        if (!medium_present)
            return ASC_NO_MEDIUM;
        if (!unit_initialised)
            return ASC_NOT_READY_OTHER;
        return ASC_NONE;
    endfunction

    function automatic void set_check(inout result_t r, input sense_key_t key, input asc_t asc);
        r.check_status = 1'b1;
        r.sense_key = key;
        r.sense_asc = asc;
        r.new_phase = PH_STATUS;
    endfunction

    // read or write setup with protection and 33-bit range check
    function automatic void begin_transfer(inout result_t r, input logic [31:0] lba,
                                           input logic [16:0] n, input bit wr);
        if (wr && cfg_write_protect)
        begin
            set_check(r, SK_ILLEGAL_REQUEST, ASC_WRITE_PROTECTED);
            return;
        end
        if (33'(lba) + 33'(n) > 33'(capacity_blocks))
        begin
            set_check(r, SK_ILLEGAL_REQUEST, ASC_LBA_OUT_OF_RANGE);
            return;
        end
        r.start_block = lba;
        r.block_count = n[15:0];
        if (n == 0)
        begin
            clear_transfer();
            r.new_phase = PH_STATUS;
            return;
        end
        xfer_length = n[15:0];
        blocks_done = '0;
        if (wr)
        begin
            r.new_phase = PH_DATA_OUT;
            r.data_length = WRITE_DATA_LEN;
            r.card_action = ACT_PREPARE_WRITE;
        end
        else
        begin
            r.new_phase = PH_DATA_IN;
            r.data_length = 10'd0;
            r.card_action = ACT_PREPARE_READ;
        end
    endfunction

    function automatic result_t decode_command(input item_t ev);
        result_t     r;
        asc_t        fault;
        logic [31:0] lba6;
        logic [31:0] lba10;
        logic [16:0] cnt6;
        logic [16:0] cnt10;
        r = '0;
        lba6 = {11'd0, ev.cdb_byte1[4:0], ev.cdb_byte2, ev.cdb_byte3};
        lba10 = {ev.cdb_byte2, ev.cdb_byte3, ev.cdb_byte4, ev.cdb_byte5};
        cnt6 = (ev.cdb_byte4 == 8'd0) ? SHORT_COUNT_ZERO : {9'd0, ev.cdb_byte4};
        cnt10 = {1'b0, ev.cdb_byte7, ev.cdb_byte8};
        r.handled = 1'b1;
        // start/stop bypasses the readiness check
        if (ev.opcode == OP_START_STOP)
        begin
            if (ev.cdb_byte4[0])
            begin
                unit_started = 1'b1;
                if (!unit_initialised)
                    card_init(ev.init_ok);
            end
            else
                unit_started = 1'b0;
            return r;
        end
        fault = ready_fault();
        if (fault != ASC_NONE)
        begin
            set_check(r, SK_NOT_READY, fault);
            return r;
        end
        case (ev.opcode)
            OP_READ6:  begin_transfer(r, lba6, cnt6, 1'b0);
            OP_READ10: begin_transfer(r, lba10, cnt10, 1'b0);
            OP_WRITE6: begin_transfer(r, lba6, cnt6, 1'b1);
            OP_WRITE10: begin_transfer(r, lba10, cnt10, 1'b1);
            OP_READ_CAPACITY:
            begin
                if (!ev.cdb_byte8[0] && lba10 != 0)
                    set_check(r, SK_ILLEGAL_REQUEST, ASC_INVALID_CDB_FIELD);
                else if (capacity_blocks != 0)
                begin
                    r.last_block = capacity_blocks - 32'd1;
                    r.block_bytes = BLOCK_BYTES;
                    r.data_length = CAPACITY_DATA_LEN;
                    r.new_phase = PH_DATA_IN;
                end
                else
                    set_check(r, SK_NOT_READY, ASC_NO_MEDIUM);
            end
            OP_SEEK6:
            begin
                if (lba6 >= capacity_blocks)
                    set_check(r, SK_ILLEGAL_REQUEST, ASC_LBA_OUT_OF_RANGE);
            end
            OP_SEEK10:
            begin
                if (lba10 >= capacity_blocks)
                    set_check(r, SK_ILLEGAL_REQUEST, ASC_LBA_OUT_OF_RANGE);
            end
            OP_TEST_UNIT_READY, OP_REZERO, OP_FORMAT_UNIT, OP_MEDIUM_REMOVAL,
            OP_PREFETCH, OP_SYNC_CACHE, OP_LOCK_CACHE: ;
            default: r.handled = 1'b0;
        endcase
        return r;
    endfunction

    // advances the unit state by one event and returns its result
    function automatic result_t advance_unit(input item_t ev);
        result_t r;
        r = '0;
        case (ev.cmd)
            EV_COMMAND:
            begin
                bus_phase = PH_COMMAND;
                r = decode_command(ev);
                if (r.new_phase != PH_COMMAND)
                    bus_phase = r.new_phase;
            end
            EV_BLOCK_DONE:
            begin
                if ((bus_phase == PH_DATA_IN || bus_phase == PH_DATA_OUT)
                    && blocks_done != xfer_length)
                begin
                    blocks_done = blocks_done + 16'd1;
                    if (blocks_done >= xfer_length)
                    begin
                        r.new_phase = PH_STATUS;
                        if (bus_phase == PH_DATA_OUT)
                            r.card_action = ACT_COMPLETE_WRITE;
                        else
                            r.card_action = ACT_COMPLETE_READ;
                        bus_phase = PH_STATUS;
                        clear_transfer();
                    end
                end
            end
            EV_POWER_ON:
            begin
                capacity_blocks = '0;
                clear_transfer();
                bus_phase = PH_COMMAND;
                unit_started = 1'b1;
                medium_present = 1'b0;
                unit_initialised = 1'b0;
                if (cfg_card_present)
                begin
                    medium_present = 1'b1;
                    card_init(ev.init_ok);
                end
            end
            default:
            begin
                clear_transfer();
                bus_phase = PH_COMMAND;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // event builders
    // ---------------------------------------------------------------

    function automatic item_t rand_item();
        item_t ev;
        ev.cmd = event_t'($urandom_range(0, 3));
        ev.opcode = 8'($urandom);
        ev.cdb_byte1 = 8'($urandom);
        ev.cdb_byte2 = 8'($urandom);
        ev.cdb_byte3 = 8'($urandom);
        ev.cdb_byte4 = 8'($urandom);
        ev.cdb_byte5 = 8'($urandom);
        ev.cdb_byte7 = 8'($urandom);
        ev.cdb_byte8 = 8'($urandom);
        ev.init_ok = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    function automatic item_t rand_command(input logic [7:0] op);
        item_t ev;
        ev = rand_item();
        ev.cmd = EV_COMMAND;
        ev.opcode = op;
        return ev;
    endfunction

    function automatic item_t block_event();
        item_t ev;
        ev = rand_item();
        ev.cmd = EV_BLOCK_DONE;
        return ev;
    endfunction

    function automatic item_t make_cdb(input logic [7:0] op, input logic [31:0] lba,
                                       input logic [15:0] cnt, input bit ten);
        item_t ev;
        ev = rand_command(op);
        if (ten)
        begin
            ev.cdb_byte2 = lba[31:24];
            ev.cdb_byte3 = lba[23:16];
            ev.cdb_byte4 = lba[15:8];
            ev.cdb_byte5 = lba[7:0];
            ev.cdb_byte7 = cnt[15:8];
            ev.cdb_byte8 = cnt[7:0];
        end
        else
        begin
            ev.cdb_byte1[4:0] = lba[20:16];
            ev.cdb_byte2 = lba[15:8];
            ev.cdb_byte3 = lba[7:0];
            ev.cdb_byte4 = cnt[7:0];
        end
        return ev;
    endfunction

    // addresses cluster around the end of the medium
    function automatic logic [31:0] pick_lba(input logic [31:0] cap, input logic [16:0] n);
        case ($urandom_range(0, 3))
            0: return cap - 32'(n) + 32'($urandom_range(0, 2)) - 32'd1;
            1: return 32'($urandom_range(0, 15));
            2: return $urandom;
            default: return cap - 32'd1 - 32'($urandom_range(0, 3));
        endcase
    endfunction

    // mostly complete transfers, then other commands, resets and noise
    function automatic void queue_traffic(input int count, input logic [31:0] cap);
        int          added;
        int          pick;
        int          steps;
        bit          ten;
        bit          wr;
        logic [16:0] n;
        logic [7:0]  op;
        item_t       ev;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                ten = 1'($urandom_range(0, 1));
                wr = 1'($urandom_range(0, 1));
                if (ten)
                    op = wr ? OP_WRITE10 : OP_READ10;
                else
                    op = wr ? OP_WRITE6 : OP_READ6;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    n = 17'($urandom_range(1, 4));
                else if (pick < 90)
                    n = ten ? 17'd0 : SHORT_COUNT_ZERO;
                else if (ten)
                    n = 17'($urandom_range(0, 65535));
                else
                    n = 17'($urandom_range(1, 256));
                pending_events.push_back(make_cdb(op, pick_lba(cap, n), n[15:0], ten));
                added++;
                steps = (n > 6) ? 3 : int'(n);
                pick = $urandom_range(0, 99);
                // cut the transfer short, or send one block too many
                if (pick < 10 && steps > 0)
                    steps--;
                else if (pick >= 10 && pick < 20)
                    steps++;
                repeat (steps)
                begin
                    pending_events.push_back(block_event());
                    added++;
                end
                if (pick < 10)
                begin
                    pending_events.push_back(rand_item());
                    added++;
                end
            end
            else if (pick < 78)
            begin
                op = MISC_OPS[$urandom_range(0, 10)];
                case (op)
                    OP_READ_CAPACITY:
                        ev = make_cdb(op, $urandom_range(0, 1) ? 32'd0 : 32'($urandom),
                                      16'($urandom), 1'b1);
                    OP_SEEK6: ev = make_cdb(op, pick_lba(cap, 17'd1), 16'($urandom), 1'b0);
                    OP_SEEK10: ev = make_cdb(op, pick_lba(cap, 17'd1), 16'($urandom), 1'b1);
                    OP_START_STOP:
                    begin
                        ev = rand_command(op);
                        ev.cdb_byte4[0] = ($urandom_range(0, 99) < 85);
                    end
                    default: ev = rand_command(op);
                endcase
                pending_events.push_back(ev);
                added++;
            end
            else if (pick < 88)
            begin
                ev = rand_item();
                ev.cmd = $urandom_range(0, 1) ? EV_POWER_ON : EV_BUS_RESET;
                ev.init_ok = ($urandom_range(0, 99) < 80);
                pending_events.push_back(ev);
                added++;
            end
            else
            begin
                pending_events.push_back(rand_item());
                added++;
            end
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        if (pick < 93)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // event driver
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(advance_unit(offered));
                if (src_idle && $urandom_range(0, 99) < 30)
                    src_gap = gap_len();
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    offered = pending_events.pop_front();
                    s_tdata <= {7'd0, offered.init_ok, offered.cdb_byte8, offered.cdb_byte7,
                                offered.cdb_byte5, offered.cdb_byte4, offered.cdb_byte3,
                                offered.cdb_byte2, offered.cdb_byte1, offered.opcode};
                    s_tuser <= offered.cmd;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result side ready, with random stalls and one long hold
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_stall = 0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            sink_stall = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 99) < 30)
        begin
            sink_stall = gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result transfer with nothing outstanding");
            else
            begin
                want = awaited_results.pop_front();
                compare_field("handled", want.handled, m_tdata[0]);
                compare_field("check_status", want.check_status, m_tdata[1]);
                compare_field("sense_key", want.sense_key, m_tdata[3:2]);
                compare_field("sense_asc", want.sense_asc, m_tdata[6:4]);
                compare_field("new_phase", want.new_phase, m_tdata[8:7]);
                compare_field("data_length", want.data_length, m_tdata[18:9]);
                compare_field("last_block", want.last_block, m_tdata[50:19]);
                compare_field("block_bytes", want.block_bytes, m_tdata[82:51]);
                compare_field("start_block", want.start_block, m_tdata[114:83]);
                compare_field("block_count", want.block_count, m_tdata[130:115]);
                compare_field("card_action", want.card_action, m_tdata[133:131]);
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------
    // watchdog: no transfer for too long while work is outstanding
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else if (pending_events.size() != 0 || s_tvalid || awaited_results.size() != 0)
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencing
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_MAX_BLOCKS: cfg_max_blocks = value;
            CFG_CARD_CAPACITY: cfg_card_capacity = value;
            CFG_WRITE_PROTECT: cfg_write_protect = value[0];
            default: cfg_card_present = value[0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until nothing is in flight, then let the pipeline empty
    task automatic settle();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] max_b, input logic [31:0] cap, input bit wp,
                             input bit present, input bit src_on, input bit sink_on,
                             input bit hold, input int count);
        logic [31:0] usable;
        item_t       ev;
        settle();
        write_reg(CFG_MAX_BLOCKS, max_b);
        write_reg(CFG_CARD_CAPACITY, cap);
        write_reg(CFG_WRITE_PROTECT, {31'd0, wp});
        write_reg(CFG_CARD_PRESENT, {31'd0, present});
        @(negedge clk);
        src_idle = src_on;
        sink_idle = sink_on;
        usable = (max_b != 0 && cap > max_b) ? max_b : cap;
        // power-on first so the new capacity takes effect
        ev = rand_item();
        ev.cmd = EV_POWER_ON;
        ev.init_ok = 1'b1;
        pending_events.push_back(ev);
        queue_traffic(count, usable);
        if (hold)
            long_hold_req = 1'b1;
    endtask

    initial
    begin
        item_t ev;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed walk through readiness, decode and transfer cases
        write_reg(CFG_MAX_BLOCKS, 32'd0);
        write_reg(CFG_CARD_CAPACITY, 32'd1000);
        write_reg(CFG_WRITE_PROTECT, 32'd0);
        write_reg(CFG_CARD_PRESENT, 32'd1);
        @(negedge clk);
        // no medium yet, unknown opcode is still rejected as not ready
        pending_events.push_back(rand_command(OP_TEST_UNIT_READY));
        pending_events.push_back(rand_command(OP_UNSUPPORTED_TOP));
        // failed initialisation at power-on
        ev = rand_item();
        ev.cmd = EV_POWER_ON;
        ev.init_ok = 1'b0;
        pending_events.push_back(ev);
        pending_events.push_back(rand_command(OP_TEST_UNIT_READY));
        // start initialises, stop makes reads need a start
        ev = rand_command(OP_START_STOP);
        ev.cdb_byte4[0] = 1'b1;
        ev.init_ok = 1'b1;
        pending_events.push_back(ev);
        ev.cdb_byte4[0] = 1'b0;
        pending_events.push_back(ev);
        pending_events.push_back(make_cdb(OP_READ6, 32'd0, 16'd1, 1'b0));
        ev.cdb_byte4[0] = 1'b1;
        ev.init_ok = 1'b0;
        pending_events.push_back(ev);
        pending_events.push_back(rand_command(OP_UNSUPPORTED));
        // capacity reply, and a nonzero address without partial medium
        pending_events.push_back(make_cdb(OP_READ_CAPACITY, 32'd0, 16'd0, 1'b1));
        pending_events.push_back(make_cdb(OP_READ_CAPACITY, 32'd5, 16'd0, 1'b1));
        // read ending exactly at the last block, then a stray block
        pending_events.push_back(make_cdb(OP_READ10, 32'd998, 16'd2, 1'b1));
        repeat (3) pending_events.push_back(block_event());
        pending_events.push_back(make_cdb(OP_READ10, 32'd999, 16'd2, 1'b1));
        // zero ten-byte count completes at once
        pending_events.push_back(make_cdb(OP_READ10, 32'd1000, 16'd0, 1'b1));
        pending_events.push_back(make_cdb(OP_WRITE6, 32'd0, 16'd1, 1'b0));
        pending_events.push_back(block_event());
        // zero six-byte count means 256 blocks, abandoned by a bus reset
        pending_events.push_back(make_cdb(OP_READ6, 32'd0, 16'd0, 1'b0));
        ev = rand_item();
        ev.cmd = EV_BUS_RESET;
        pending_events.push_back(ev);
        pending_events.push_back(block_event());
        pending_events.push_back(make_cdb(OP_SEEK6, 32'd999, 16'd0, 1'b0));
        pending_events.push_back(make_cdb(OP_SEEK10, 32'd1000, 16'd0, 1'b1));
        foreach (NOOP_OPS[i])
            pending_events.push_back(rand_command(NOOP_OPS[i]));

        // random phases over several settings
        run_phase(32'd0, 32'd1000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 110);
        run_phase(32'd200, 32'd5000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 110);
        run_phase(32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 110);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 110);
        run_phase(32'd64, 32'd32, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 60);
        run_phase($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 300)),
                  32'($urandom_range(0, 400)), 1'($urandom_range(0, 1)), 1'b1,
                  1'b1, 1'b1, 1'b0, 110);

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
